/* rtl/cfr_pkg.sv */
`timescale 1ns / 1ps

package cfr_pkg;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_START_BYTE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_LINGO_ID   = 2'd1;

  // reset values of the configuration registers
  localparam logic [7:0] START_BYTE_RST = 8'h55;
  localparam logic [7:0] LINGO_ID_RST   = 8'h00;

  // header bytes counted in the length field
  localparam logic [7:0] HDR_LEN = 8'd4;

  // result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_FRAME   = 1'b1;

  // registered input byte handed from the input stage to the parser
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } cfr_stage_t;

endpackage

/* rtl/cfr_if.sv */
`timescale 1ns / 1ps

// received byte channel
interface cfr_rx_if
  import cfr_pkg::*;
;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source(output valid, output rx_byte, input ready);
  modport sink(input valid, input rx_byte, output ready);
endinterface

// result channel
interface cfr_res_if
  import cfr_pkg::*;
;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [7:0]  payload_byte;
  logic [7:0]  payload_index;
  logic [7:0]  command_code;
  logic [15:0] frame_trans_id;
  logic [7:0]  payload_count;
  logic        frame_good;
  logic [15:0] stored_trans_id;

  modport source(
    output valid, output result_kind, output payload_byte, output payload_index,
    output command_code, output frame_trans_id, output payload_count,
    output frame_good, output stored_trans_id, input ready
  );
  modport sink(
    input valid, input result_kind, input payload_byte, input payload_index,
    input command_code, input frame_trans_id, input payload_count,
    input frame_good, input stored_trans_id, output ready
  );
endinterface

// configuration write channel
interface cfr_cfg_if
  import cfr_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [7:0]         data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

/* rtl/cfr_in_stage.sv */
`timescale 1ns / 1ps

module cfr_in_stage
  import cfr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  cfr_rx_if.sink     rx_i,
  input  logic       advance_i,
  output cfr_stage_t stage_o
);

  logic       valid_q, valid_d;
  logic [7:0] data_q, data_d;
  logic       take;

  // room when empty or when the parser consumes the held item
  assign rx_i.ready = !valid_q || advance_i;
  assign take       = rx_i.valid && rx_i.ready;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (advance_i) begin
      valid_d = 1'b0;
    end
    if (take) begin
      valid_d = 1'b1;
      data_d  = rx_i.rx_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // byte register, no reset needed
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign stage_o.valid = valid_q;
  assign stage_o.data  = data_q;

endmodule

/* rtl/cfr_parser.sv */
`timescale 1ns / 1ps

module cfr_parser
  import cfr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfr_stage_t stage_i,
  output logic       advance_o,
  input  logic [7:0] start_byte_i,
  input  logic [7:0] lingo_id_i,
  cfr_res_if.source  res_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_LEN, ST_LINGO, ST_CMD, ST_IDHI, ST_IDLO, ST_DATA, ST_SUM
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  frame_length_q, frame_length_d;
  logic [7:0]  frame_command_q, frame_command_d;
  logic [15:0] frame_id_q, frame_id_d;
  logic [7:0]  running_sum_q, running_sum_d;
  logic [7:0]  bytes_left_q, bytes_left_d;
  logic [15:0] accepted_id_q, accepted_id_d;

  logic        res_valid_q, res_valid_d;
  logic        res_kind_q, res_kind_d;
  logic [7:0]  res_byte_q, res_byte_d;
  logic [7:0]  res_index_q, res_index_d;
  logic [7:0]  res_cmd_q, res_cmd_d;
  logic [15:0] res_tid_q, res_tid_d;
  logic [7:0]  res_count_q, res_count_d;
  logic        res_good_q, res_good_d;
  logic [15:0] res_stored_q, res_stored_d;

  logic        out_space;
  logic [7:0]  pay_len;
  logic [7:0]  expect_sum;
  logic        len_ok;
  logic        good;
  logic [7:0]  b;

  // the result register frees up when empty or being taken
  assign out_space = !res_valid_q || res_o.ready;
  assign advance_o = stage_i.valid && out_space;
  assign b         = stage_i.data;

  assign len_ok     = frame_length_q >= HDR_LEN;
  assign pay_len    = len_ok ? frame_length_q - HDR_LEN : 8'd0;
  assign expect_sum = (running_sum_q ^ 8'hFF) + 8'h01;
  assign good       = (b == expect_sum) && len_ok;

  // next state and result
  always_comb begin
    phase_d         = phase_q;
    frame_length_d  = frame_length_q;
    frame_command_d = frame_command_q;
    frame_id_d      = frame_id_q;
    running_sum_d   = running_sum_q;
    bytes_left_d    = bytes_left_q;
    accepted_id_d   = accepted_id_q;

    res_valid_d  = res_valid_q && !res_o.ready;
    res_kind_d   = res_kind_q;
    res_byte_d   = res_byte_q;
    res_index_d  = res_index_q;
    res_cmd_d    = res_cmd_q;
    res_tid_d    = res_tid_q;
    res_count_d  = res_count_q;
    res_good_d   = res_good_q;
    res_stored_d = res_stored_q;

    if (advance_o) begin
      case (phase_q)
        ST_IDLE: begin
          if (b == start_byte_i) begin
            running_sum_d = 8'd0;
            phase_d       = ST_LEN;
          end
        end
        ST_LEN: begin
          frame_length_d = b;
          running_sum_d  = running_sum_q + b;
          phase_d        = ST_LINGO;
        end
        ST_LINGO: begin
          // received lingo byte is replaced by the configured one
          running_sum_d = running_sum_q + lingo_id_i;
          phase_d       = ST_CMD;
        end
        ST_CMD: begin
          frame_command_d = b;
          running_sum_d   = running_sum_q + b;
          phase_d         = ST_IDHI;
        end
        ST_IDHI: begin
          frame_id_d    = {b, 8'd0};
          running_sum_d = running_sum_q + b;
          phase_d       = ST_IDLO;
        end
        ST_IDLO: begin
          frame_id_d    = {frame_id_q[15:8], b};
          running_sum_d = running_sum_q + b;
          bytes_left_d  = pay_len;
          phase_d       = (pay_len != 8'd0) ? ST_DATA : ST_SUM;
        end
        ST_DATA: begin
          running_sum_d = running_sum_q + b;
          bytes_left_d  = bytes_left_q - 8'd1;
          if (bytes_left_q == 8'd1) begin
            phase_d = ST_SUM;
          end
          res_valid_d  = 1'b1;
          res_kind_d   = KIND_PAYLOAD;
          res_byte_d   = b;
          res_index_d  = pay_len - bytes_left_q;
          res_cmd_d    = frame_command_q;
          res_tid_d    = frame_id_q;
          res_count_d  = pay_len;
          res_good_d   = 1'b0;
          res_stored_d = accepted_id_q;
        end
        ST_SUM: begin
          if (good) begin
            accepted_id_d = frame_id_q;
          end
          phase_d      = ST_IDLE;
          res_valid_d  = 1'b1;
          res_kind_d   = KIND_FRAME;
          res_byte_d   = 8'd0;
          res_index_d  = 8'd0;
          res_cmd_d    = frame_command_q;
          res_tid_d    = frame_id_q;
          res_count_d  = pay_len;
          res_good_d   = good;
          res_stored_d = good ? frame_id_q : accepted_id_q;
        end
        default: begin
          phase_d = ST_IDLE;
        end
      endcase
    end
  end

  // frame state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= ST_IDLE;
      frame_length_q  <= 8'd0;
      frame_command_q <= 8'd0;
      frame_id_q      <= 16'd0;
      running_sum_q   <= 8'd0;
      bytes_left_q    <= 8'd0;
      accepted_id_q   <= 16'd0;
      res_valid_q     <= 1'b0;
    end else begin
      phase_q         <= phase_d;
      frame_length_q  <= frame_length_d;
      frame_command_q <= frame_command_d;
      frame_id_q      <= frame_id_d;
      running_sum_q   <= running_sum_d;
      bytes_left_q    <= bytes_left_d;
      accepted_id_q   <= accepted_id_d;
      res_valid_q     <= res_valid_d;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    res_kind_q   <= res_kind_d;
    res_byte_q   <= res_byte_d;
    res_index_q  <= res_index_d;
    res_cmd_q    <= res_cmd_d;
    res_tid_q    <= res_tid_d;
    res_count_q  <= res_count_d;
    res_good_q   <= res_good_d;
    res_stored_q <= res_stored_d;
  end

  assign res_o.valid           = res_valid_q;
  assign res_o.result_kind     = res_kind_q;
  assign res_o.payload_byte    = res_byte_q;
  assign res_o.payload_index   = res_index_q;
  assign res_o.command_code    = res_cmd_q;
  assign res_o.frame_trans_id  = res_tid_q;
  assign res_o.payload_count   = res_count_q;
  assign res_o.frame_good      = res_good_q;
  assign res_o.stored_trans_id = res_stored_q;

  // payload phase always has bytes still to read
  a_data_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == ST_DATA |-> bytes_left_q != 8'd0)
    else $error("payload phase with no bytes left");

  // checksum byte always yields a frame result
  a_sum_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_o && phase_q == ST_SUM |=> res_valid_q && res_kind_q == KIND_FRAME)
    else $error("checksum byte gave no frame result");

  // short frames are never good
  a_short_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_o && phase_q == ST_SUM && !len_ok |=> !res_good_q)
    else $error("short frame flagged good");

  // stored id only changes on a checksum byte
  a_id_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(accepted_id_q) |-> $past(advance_o && phase_q == ST_SUM))
    else $error("stored id changed outside a checksum byte");

endmodule

/* rtl/checksummed_frame_receiver_unit.sv */
`timescale 1ns / 1ps
// path: input register holds the accepted byte, result register then holds its result
// throughput: one byte per cycle, set by the single state update between input and result
// registers; a full result register that is not taken stalls the input register
// reset: asynchronous active low; returns to idle, clears frame state and stored id,
// start byte to 0x55 and lingo id to 0

module checksummed_frame_receiver_unit
  import cfr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  cfr_cfg_if.sink   cfg_i,
  cfr_rx_if.sink    rx_i,
  cfr_res_if.source res_o
);

  logic [7:0] start_byte_q;
  logic [7:0] lingo_id_q;
  cfr_stage_t stage;
  logic       advance;

  // configuration registers, writes to unknown indexes are dropped
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= START_BYTE_RST;
      lingo_id_q   <= LINGO_ID_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_START_BYTE: start_byte_q <= cfg_i.data;
        CFG_LINGO_ID:   lingo_id_q   <= cfg_i.data;
        default: ;
      endcase
    end
  end

  cfr_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rx_i      (rx_i),
    .advance_i (advance),
    .stage_o   (stage)
  );

  cfr_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .stage_i      (stage),
    .advance_o    (advance),
    .start_byte_i (start_byte_q),
    .lingo_id_i   (lingo_id_q),
    .res_o        (res_o)
  );

endmodule

/* tb/checksummed_frame_receiver_unit_test.sv */
`timescale 1ns / 1ps

module checksummed_frame_receiver_unit_test;
  import cfr_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1650;
  localparam int unsigned RANDOM_PHASES = 6;
  localparam int unsigned HOLD_CYCLES = 150;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned MAX_PRINTS = 40;

  // indexes that map to no register
  localparam logic [CfgIdxW-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_B = 2'd3;

  typedef enum logic [2:0] {
    FR_IDLE, FR_LEN, FR_LINGO, FR_CMD, FR_IDHI, FR_IDLO, FR_DATA, FR_CHECK
  } rx_phase_e;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data;
    logic [7:0]  pos;
    logic [7:0]  cmd;
    logic [15:0] tid;
    logic [7:0]  count;
    logic        good;
    logic [15:0] stored;
  } frame_result_t;

  logic clk;
  logic rst_n;

  cfr_cfg_if cfg_bus();
  cfr_rx_if  rx_bus();
  cfr_res_if res_bus();

  checksummed_frame_receiver_unit uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cfg_i (cfg_bus),
    .rx_i  (rx_bus),
    .res_o (res_bus)
  );

  // parser model state and register copies
  rx_phase_e   fr_phase;
  logic [7:0]  fr_len;
  logic [7:0]  fr_cmd;
  logic [15:0] fr_tid;
  logic [7:0]  fr_sum;
  logic [7:0]  fr_left;
  logic [15:0] fr_stored;
  logic [7:0]  start_cfg;
  logic [7:0]  lingo_cfg;

  frame_result_t awaited_results[$];

  int unsigned error_count = 0;
  int unsigned stall_cycles = 0;
  int unsigned hold_left = 0;
  bit          hold_request = 1'b0;
  bit          src_steady = 1'b0;
  bit          sink_steady = 1'b0;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    error_count++;
    if (error_count <= MAX_PRINTS)
      $display("%0t ns: %s mismatch: got %h, expected %h", $realtime, what, got, want);
  endtask

  function automatic void reset_parser();
    fr_phase  = FR_IDLE;
    fr_len    = 8'h00;
    fr_cmd    = 8'h00;
    fr_tid    = 16'h0000;
    fr_sum    = 8'h00;
    fr_left   = 8'h00;
    fr_stored = 16'h0000;
    start_cfg = START_BYTE_RST;
    lingo_cfg = LINGO_ID_RST;
  endfunction

  // advance the parser by one received byte and queue what it emits
  function automatic void parse_rx_byte(input logic [7:0] b);
    frame_result_t r;
    logic [7:0]    body;
    logic [7:0]    want_sum;
    logic          emit;
    r    = '0;
    emit = 1'b0;
    body = (fr_len >= HDR_LEN) ? fr_len - HDR_LEN : 8'h00;
    case (fr_phase)
      FR_IDLE: begin
        if (b == start_cfg) begin
          fr_sum   = 8'h00;
          fr_phase = FR_LEN;
        end
      end
      FR_LEN: begin
        fr_len   = b;
        fr_sum   = fr_sum + b;
        fr_phase = FR_LINGO;
      end
      FR_LINGO: begin
        // the received lingo byte is dropped, the configured one is summed
        fr_sum   = fr_sum + lingo_cfg;
        fr_phase = FR_CMD;
      end
      FR_CMD: begin
        fr_cmd   = b;
        fr_sum   = fr_sum + b;
        fr_phase = FR_IDHI;
      end
      FR_IDHI: begin
        fr_tid   = {b, 8'h00};
        fr_sum   = fr_sum + b;
        fr_phase = FR_IDLO;
      end
      FR_IDLO: begin
        fr_tid[7:0] = b;
        fr_sum      = fr_sum + b;
        fr_left     = body;
        fr_phase    = (body != 8'h00) ? FR_DATA : FR_CHECK;
      end
      FR_DATA: begin
        r.kind  = KIND_PAYLOAD;
        r.data  = b;
        r.pos   = body - fr_left;
        fr_sum  = fr_sum + b;
        fr_left = fr_left - 8'h01;
        if (fr_left == 8'h00) fr_phase = FR_CHECK;
        emit = 1'b1;
      end
      default: begin
        want_sum = ~fr_sum + 8'h01;
        r.kind   = KIND_FRAME;
        r.good   = (b == want_sum) && (fr_len >= HDR_LEN);
        if (r.good) fr_stored = fr_tid;
        fr_phase = FR_IDLE;
        emit     = 1'b1;
      end
    endcase
    if (emit) begin
      r.cmd    = fr_cmd;
      r.tid    = fr_tid;
      r.count  = body;
      r.stored = fr_stored;
      awaited_results.push_back(r);
    end
  endfunction

  // offer one byte, with random gaps, until it is taken
  task automatic send_byte(input logic [7:0] b);
    while (!src_steady && $urandom_range(99) < 20) begin
      rx_bus.valid <= 1'b0;
      @(posedge clk);
    end
    rx_bus.valid   <= 1'b1;
    rx_bus.rx_byte <= b;
    do @(posedge clk); while (rx_bus.ready !== 1'b1);
    parse_rx_byte(b);
  endtask

  // stop sending and let every item in flight come out
  task automatic settle();
    rx_bus.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [7:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    case (idx)
      CFG_START_BYTE: start_cfg = value;
      CFG_LINGO_ID:   lingo_cfg = value;
      default: ;
    endcase
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  // one whole frame; the checksum is built here, apart from the parser model
  task automatic send_frame(input logic [7:0] len, input logic [7:0] cmd,
                            input logic [15:0] tid, input bit bad,
                            input bit swap_lingo, input bit start_heavy);
    logic [7:0] sum;
    logic [7:0] b;
    logic [7:0] lingo_used;
    int         n;
    n = (len >= HDR_LEN) ? int'(len - HDR_LEN) : 0;
    send_byte(start_cfg);
    send_byte(len);
    if (swap_lingo) begin
      settle();
      b = 8'($urandom_range(255));
      cfg_write(CFG_LINGO_ID, b);
    end
    lingo_used = lingo_cfg;
    b = 8'($urandom_range(255));
    send_byte((start_heavy || $urandom_range(3) == 0) ? start_cfg : b);
    send_byte(cmd);
    send_byte(tid[15:8]);
    send_byte(tid[7:0]);
    sum = len + lingo_used + cmd + tid[15:8] + tid[7:0];
    repeat (n) begin
      b = 8'($urandom_range(255));
      if (start_heavy || $urandom_range(7) == 0) b = start_cfg;
      sum = sum + b;
      send_byte(b);
    end
    sum = ~sum + 8'h01;
    if (bad) begin
      b = 8'($urandom_range(1, 255));
      sum = sum ^ b;
    end
    send_byte(sum);
  endtask

  // defaults after reset, idle noise, plain and empty frames
  task automatic test_reset_values();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(8'd7, 8'h00, 16'h0000, 1'b0, 1'b0, 1'b0);
    send_frame(8'd4, 8'hFF, 16'hFFFF, 1'b0, 1'b0, 1'b0);
  endtask

  // short lengths, wrong checksums, start byte as frame data
  task automatic test_frame_cases();
    send_frame(8'd0, 8'hA5, 16'h1234, 1'b0, 1'b0, 1'b0);
    send_frame(8'd3, 8'h5A, 16'hABCD, 1'b1, 1'b0, 1'b0);
    send_frame(8'd5, 8'h81, 16'h8001, 1'b1, 1'b0, 1'b0);
    send_frame(8'd6, 8'h7E, 16'h00FF, 1'b0, 1'b0, 1'b1);
  endtask

  // register extremes, spare indexes, lingo change in the middle of a frame
  task automatic test_config_registers();
    settle();
    cfg_write(CFG_START_BYTE, 8'h00);
    cfg_write(CFG_LINGO_ID, 8'hFF);
    send_byte(START_BYTE_RST);
    send_frame(8'd6, 8'h3C, 16'hFF00, 1'b0, 1'b0, 1'b0);
    settle();
    cfg_write(CFG_START_BYTE, 8'hFF);
    cfg_write(CFG_LINGO_ID, 8'h00);
    send_frame(8'd5, 8'hC3, 16'h0F0F, 1'b0, 1'b0, 1'b1);
    settle();
    cfg_write(CFG_SPARE_A, 8'h00);
    cfg_write(CFG_SPARE_B, 8'hFF);
    send_frame(8'd4, 8'h11, 16'h2222, 1'b0, 1'b0, 1'b0);
    send_frame(8'd6, 8'h44, 16'h5555, 1'b0, 1'b1, 1'b0);
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_back_pressure();
    settle();
    src_steady   = 1'b1;
    hold_request = 1'b1;
    send_frame(8'd64, 8'h99, 16'hBEEF, 1'b0, 1'b0, 1'b0);
    src_steady = 1'b0;
  endtask

  function automatic logic [7:0] pick_cfg_value();
    logic [7:0] v;
    case ($urandom_range(3))
      0: v = 8'h00;
      1: v = 8'hFF;
      default: v = 8'($urandom_range(255));
    endcase
    return v;
  endfunction

  // mostly well formed frames with random content, some noise and broken frames
  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned r;
    int unsigned k;
    logic [7:0]  b;
    logic [7:0]  len;
    logic [15:0] tid;
    bit          big_done;
    big_done = 1'b0;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      cfg_write(CFG_START_BYTE, pick_cfg_value());
      cfg_write(CFG_LINGO_ID, pick_cfg_value());
      src_steady  = (ph == 2);
      sink_steady = (ph == 2);
      sent = 0;
      while (sent < RANDOM_ITEMS / RANDOM_PHASES) begin
        // idle noise that never opens a frame
        repeat ($urandom_range(2)) begin
          do b = 8'($urandom_range(255)); while (b == start_cfg);
          send_byte(b);
        end
        r = $urandom_range(99);
        if (r < 5) begin
          // truncated header, then bytes until the parser closes the frame
          send_byte(start_cfg);
          k = $urandom_range(1, 4);
          repeat (k) begin
            b = 8'($urandom_range(255));
            send_byte(b);
          end
          sent += k + 1;
          while (fr_phase != FR_IDLE) begin
            b = 8'($urandom_range(255));
            send_byte(b);
            sent++;
          end
        end else begin
          if (ph == 3 && !big_done) begin
            len = 8'hFF;
            big_done = 1'b1;
          end else if (r < 17) begin
            len = 8'($urandom_range(3));
          end else begin
            len = HDR_LEN + 8'($urandom_range(16));
          end
          tid = 16'($urandom_range(16'hFFFF));
          send_frame(len, 8'($urandom_range(255)), tid, $urandom_range(9) == 0,
                     $urandom_range(49) == 0, $urandom_range(29) == 0);
          sent += (len >= HDR_LEN) ? len + 3 : 7;
        end
      end
    end
    src_steady  = 1'b0;
    sink_steady = 1'b0;
  endtask

  // result receiver with random stalls and a requested long hold
  initial begin
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= sink_steady || ($urandom_range(99) >= 20);
      end
    end
  end

  // compare each taken result with the oldest expectation
  always @(posedge clk) begin
    frame_result_t want;
    if (res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("result with nothing expected", 16'(res_bus.result_kind), 16'h0000);
      end else begin
        want = awaited_results.pop_front();
        if (res_bus.result_kind !== want.kind)
          report_mismatch("result_kind", 16'(res_bus.result_kind), 16'(want.kind));
        if (res_bus.payload_byte !== want.data)
          report_mismatch("payload_byte", 16'(res_bus.payload_byte), 16'(want.data));
        if (res_bus.payload_index !== want.pos)
          report_mismatch("payload_index", 16'(res_bus.payload_index), 16'(want.pos));
        if (res_bus.command_code !== want.cmd)
          report_mismatch("command_code", 16'(res_bus.command_code), 16'(want.cmd));
        if (res_bus.frame_trans_id !== want.tid)
          report_mismatch("frame_trans_id", res_bus.frame_trans_id, want.tid);
        if (res_bus.payload_count !== want.count)
          report_mismatch("payload_count", 16'(res_bus.payload_count), 16'(want.count));
        if (res_bus.frame_good !== want.good)
          report_mismatch("frame_good", 16'(res_bus.frame_good), 16'(want.good));
        if (res_bus.stored_trans_id !== want.stored)
          report_mismatch("stored_trans_id", res_bus.stored_trans_id, want.stored);
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((rx_bus.valid === 1'b1 && rx_bus.ready === 1'b1) ||
        (res_bus.valid === 1'b1 && res_bus.ready === 1'b1) ||
        (cfg_bus.valid === 1'b1 && cfg_bus.ready === 1'b1))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // test sequence
  initial begin
    rst_n = 1'b0;
    rx_bus.valid   <= 1'b0;
    rx_bus.rx_byte <= 8'h00;
    cfg_bus.valid  <= 1'b0;
    cfg_bus.index  <= CFG_START_BYTE;
    cfg_bus.data   <= 8'h00;
    reset_parser();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_frame_cases();
    test_config_registers();
    test_back_pressure();
    test_random_traffic();

    rx_bus.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (2 * DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && awaited_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/cfr_pkg.sv
rtl/cfr_if.sv
rtl/cfr_in_stage.sv
rtl/cfr_parser.sv
rtl/checksummed_frame_receiver_unit.sv
tb/checksummed_frame_receiver_unit_test.sv
